FILE: hdl/ert_pkg.sv
// Shared types and codes for the expense record tokenizer.
// Used by ert_parser and expense_record_tokenizer; depends on nothing.
package ert_pkg;

  // Fixed width of the token length field.
  localparam int unsigned LenWidth = 32;

  // Number of result slots one input beat can fill.
  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    EV_TOKEN     = 2'd0,
    EV_PARSE_ERR = 2'd1,
    EV_UNEXP_END = 2'd2,
    EV_FINISHED  = 2'd3
  } event_e;

  typedef enum logic [3:0] {
    SUBJ_AMOUNT  = 4'd0,
    SUBJ_YEAR    = 4'd1,
    SUBJ_MONTH   = 4'd2,
    SUBJ_DAY     = 4'd3,
    SUBJ_PERSON  = 4'd4,
    SUBJ_SHOP    = 4'd5,
    SUBJ_TAG     = 4'd6,
    SUBJ_NOTE    = 4'd7,
    SUBJ_SPACES  = 4'd8,
    SUBJ_DASH1   = 4'd9,
    SUBJ_DASH2   = 4'd10,
    SUBJ_TAGS    = 4'd11
  } subject_e;

  // Control part of one result; positions come from the token or cursor snapshot.
  typedef struct packed {
    event_e   ev;
    subject_e subj;
    logic     rend;
    logic     use_tok;
  } res_ctrl_t;

  // All results caused by one input beat.
  typedef struct packed {
    logic [1:0]                 cnt;
    res_ctrl_t [MaxResults-1:0] slot;
  } bundle_t;

endpackage

FILE: hdl/expense_record_tokenizer.sv
// Expense record tokenizer top level: input handshake and result buffer.
// Depends on ert_pkg and ert_parser.
//
// Usage: the input channel carries one beat per text byte (kind_i = 0) or an
// end-of-data marker (kind_i = 1). The parser updates its state in the cycle a
// beat is accepted and loads every result of that beat (zero to three) into
// the result buffer, which shows them on the output channel one per cycle
// from the next cycle on; last_o marks the final result of a beat.
// Throughput: one input beat per cycle while each beat yields at most one
// result and out_stall_i is low; a beat with more results holds off the input
// until the buffer's final result leaves, and the next beat is taken in that cycle.
// Beats that yield no result pass without using the buffer.
// Stall: while out_stall_i is high the current result holds and in_stall_o is
// raised once the buffer has nothing more to free up.
// Reset: the parser returns to the start of a record at offset 0, line 1,
// column 1 and the buffer empties. After an error or the end of data the
// parser halts and accepts further beats without results until reset.
module expense_record_tokenizer #(
  parameter int unsigned OFFSET_WIDTH = 32,
  parameter int unsigned LINE_WIDTH   = 20,
  parameter int unsigned COL_WIDTH    = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         kind_i,
  input  logic [7:0]                   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   event_res_o,
  output logic [3:0]                   subject_o,
  output logic [OFFSET_WIDTH-1:0]      start_offset_o,
  output logic [ert_pkg::LenWidth-1:0] token_length_o,
  output logic [LINE_WIDTH-1:0]        start_line_o,
  output logic [COL_WIDTH-1:0]         start_col_o,
  output logic                         record_end_o,
  output logic                         last_o
);

  ert_pkg::bundle_t             bundle;
  logic [OFFSET_WIDTH-1:0]      tok_off, cur_off;
  logic [ert_pkg::LenWidth-1:0] tok_len;
  logic [LINE_WIDTH-1:0]        tok_line, cur_line;
  logic [COL_WIDTH-1:0]         tok_col, cur_col;
  logic                         in_acc, out_acc, load;

  ert_pkg::res_ctrl_t [ert_pkg::MaxResults-1:0] slot_q;
  ert_pkg::res_ctrl_t           sel;
  logic [1:0]                   cnt_q, cnt_d;
  logic [1:0]                   idx_q, idx_d;
  logic [OFFSET_WIDTH-1:0]      tok_off_q, cur_off_q;
  logic [ert_pkg::LenWidth-1:0] tok_len_q;
  logic [LINE_WIDTH-1:0]        tok_line_q, cur_line_q;
  logic [COL_WIDTH-1:0]         tok_col_q, cur_col_q;

  // Input is taken once the buffer is empty or hands over its final result.
  assign in_stall_o = (cnt_q > 2'd1) || ((cnt_q == 2'd1) && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;
  assign load       = in_acc && (bundle.cnt != 2'd0);

  ert_parser #(
    .OFFSET_WIDTH(OFFSET_WIDTH),
    .LINE_WIDTH  (LINE_WIDTH),
    .COL_WIDTH   (COL_WIDTH)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (in_acc),
    .kind_i     (kind_i),
    .data_byte_i(data_byte_i),
    .bundle_o   (bundle),
    .tok_off_o  (tok_off),
    .tok_len_o  (tok_len),
    .tok_line_o (tok_line),
    .tok_col_o  (tok_col),
    .cur_off_o  (cur_off),
    .cur_line_o (cur_line),
    .cur_col_o  (cur_col)
  );

  // Buffer occupancy and read pointer.
  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load) begin
      cnt_d = bundle.cnt;
      idx_d = 2'd0;
    end else if (out_acc) begin
      cnt_d = cnt_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Result payload, loaded with the whole bundle of one beat.
  always_ff @(posedge clk_i) begin
    if (load) begin
      slot_q     <= bundle.slot;
      tok_off_q  <= tok_off;
      tok_len_q  <= tok_len;
      tok_line_q <= tok_line;
      tok_col_q  <= tok_col;
      cur_off_q  <= cur_off;
      cur_line_q <= cur_line;
      cur_col_q  <= cur_col;
    end
  end

  // Output selection for the result at the read pointer.
  assign sel            = slot_q[idx_q];
  assign out_valid_o    = (cnt_q != 2'd0);
  assign event_res_o    = sel.ev;
  assign subject_o      = sel.subj;
  assign record_end_o   = sel.rend;
  assign last_o         = (cnt_q == 2'd1);
  assign start_offset_o = sel.use_tok ? tok_off_q : cur_off_q;
  assign token_length_o = sel.use_tok ? tok_len_q : '0;
  assign start_line_o   = sel.use_tok ? tok_line_q : cur_line_q;
  assign start_col_o    = sel.use_tok ? tok_col_q : cur_col_q;

  // The read pointer never runs past the loaded results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, idx_q} + {1'b0, cnt_q} <= 3'd3))
    else $error("result buffer pointer beyond loaded results");

  // Only note tokens close a record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_end_o |->
      (subject_o == ert_pkg::SUBJ_NOTE) && (event_res_o == ert_pkg::EV_TOKEN))
    else $error("record end on a result that is not a note token");

  // Errors and the finish event are always the final result of their beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o != ert_pkg::EV_TOKEN) |-> last_o)
    else $error("error or finish event followed by more results");

  // Handing over the final result without a new load empties the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && last_o && !load |=> !out_valid_o)
    else $error("result buffer not empty after its final result");

endmodule

FILE: hdl/ert_parser.sv
// Record parser state machine with position and token counters.
// Depends on ert_pkg; produces the result bundle for each accepted beat.
module ert_parser #(
  parameter int unsigned OFFSET_WIDTH = 32,
  parameter int unsigned LINE_WIDTH   = 20,
  parameter int unsigned COL_WIDTH    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           kind_i,
  input  logic [7:0]                     data_byte_i,
  output ert_pkg::bundle_t               bundle_o,
  output logic [OFFSET_WIDTH-1:0]        tok_off_o,
  output logic [ert_pkg::LenWidth-1:0]   tok_len_o,
  output logic [LINE_WIDTH-1:0]          tok_line_o,
  output logic [COL_WIDTH-1:0]           tok_col_o,
  output logic [OFFSET_WIDTH-1:0]        cur_off_o,
  output logic [LINE_WIDTH-1:0]          cur_line_o,
  output logic [COL_WIDTH-1:0]           cur_col_o
);

  typedef enum logic [21:0] {
    PH_SKIP0        = 22'h000001,
    PH_AMT_INT      = 22'h000002,
    PH_AMT_DOT      = 22'h000004,
    PH_FRAC1        = 22'h000008,
    PH_FRAC2        = 22'h000010,
    PH_SKIP1        = 22'h000020,
    PH_YEAR         = 22'h000040,
    PH_DASH1        = 22'h000080,
    PH_MONTH_START  = 22'h000100,
    PH_MONTH        = 22'h000200,
    PH_DASH2        = 22'h000400,
    PH_DAY_START    = 22'h000800,
    PH_DAY          = 22'h001000,
    PH_AFTER_DAY    = 22'h002000,
    PH_SKIP_PERSON  = 22'h004000,
    PH_PERSON       = 22'h008000,
    PH_SKIP_SHOP    = 22'h010000,
    PH_SHOP         = 22'h020000,
    PH_TAG_START    = 22'h040000,
    PH_TAG          = 22'h080000,
    PH_NOTE_SKIP    = 22'h100000,
    PH_NOTE         = 22'h200000
  } phase_e;

  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChDash  = 8'h2D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [2:0] YearDigits = 3'd4;
  localparam logic [2:0] PairDigits = 3'd2;

  // A result that reports the current token.
  function automatic ert_pkg::res_ctrl_t tok_res(ert_pkg::subject_e subj, logic rend);
    ert_pkg::res_ctrl_t r;
    r.ev      = ert_pkg::EV_TOKEN;
    r.subj    = subj;
    r.rend    = rend;
    r.use_tok = 1'b1;
    return r;
  endfunction

  // A result that reports the cursor position with zero length.
  function automatic ert_pkg::res_ctrl_t cur_res(ert_pkg::event_e ev,
                                                 ert_pkg::subject_e subj, logic rend);
    ert_pkg::res_ctrl_t r;
    r.ev      = ev;
    r.subj    = subj;
    r.rend    = rend;
    r.use_tok = 1'b0;
    return r;
  endfunction

  phase_e                      phase_q, phase_d;
  logic [2:0]                  dcnt_q, dcnt_d;
  logic                        tag_seen_q, tag_seen_d;
  logic                        halted_q, halted_d;
  logic [OFFSET_WIDTH-1:0]     ofs_q, ofs_d;
  logic [LINE_WIDTH-1:0]       line_q, line_d;
  logic [COL_WIDTH-1:0]        col_q, col_d;
  logic [OFFSET_WIDTH-1:0]     tofs_q, tofs_d;
  logic [LINE_WIDTH-1:0]       tline_q, tline_d;
  logic [COL_WIDTH-1:0]        tcol_q, tcol_d;
  logic [ert_pkg::LenWidth-1:0] tcnt_q, tcnt_d;

  logic eof, sp, dg, is_nl, is_dot, is_dash, is_comma;
  logic tok_start, tok_grow, halt_now;
  logic [2:0] dcnt_inc;
  ert_pkg::bundle_t bd;

  // Byte classes.
  assign eof      = kind_i;
  assign sp       = (data_byte_i == 8'd32) || (data_byte_i >= 8'd9 && data_byte_i <= 8'd13);
  assign dg       = (data_byte_i >= 8'h30) && (data_byte_i <= 8'h39);
  assign is_nl    = (data_byte_i == ChNl);
  assign is_dot   = (data_byte_i == ChDot);
  assign is_dash  = (data_byte_i == ChDash);
  assign is_comma = (data_byte_i == ChComma);
  assign dcnt_inc = dcnt_q + 3'd1;

  // Phase transitions and result selection for one beat.
  always_comb begin
    bd         = '0;
    phase_d    = phase_q;
    dcnt_d     = dcnt_q;
    tag_seen_d = tag_seen_q;
    tok_start  = 1'b0;
    tok_grow   = 1'b0;
    halt_now   = 1'b0;
    if (!halted_q) begin
      unique case (phase_q)
        PH_SKIP0: begin
          if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (!sp) begin
            tok_start = 1'b1;
            if (dg) begin
              phase_d = PH_AMT_INT;
            end else begin
              bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_AMOUNT, 1'b0);
              bd.cnt = bd.cnt + 2'd1;
              halt_now = 1'b1;
            end
          end
        end
        PH_AMT_INT: begin
          if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (dg) begin
            tok_grow = 1'b1;
          end else if (is_dot) begin
            tok_grow = 1'b1;
            phase_d  = PH_AMT_DOT;
          end else if (sp) begin
            bd.slot[bd.cnt] = tok_res(ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            phase_d = PH_SKIP1;
          end else begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_SPACES, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end
        end
        PH_AMT_DOT: begin
          if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (dg) begin
            tok_grow = 1'b1;
            phase_d  = PH_FRAC1;
          end else begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end
        end
        PH_FRAC1: begin
          if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (dg) begin
            tok_grow = 1'b1;
            phase_d  = PH_FRAC2;
          end else if (sp) begin
            bd.slot[bd.cnt] = tok_res(ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            phase_d = PH_SKIP1;
          end else begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_SPACES, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end
        end
        PH_FRAC2: begin
          if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_SPACES, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (sp) begin
            bd.slot[bd.cnt] = tok_res(ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            phase_d = PH_SKIP1;
          end else begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_SPACES, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end
        end
        PH_SKIP1, PH_MONTH_START, PH_DAY_START: begin
          // First digit of a date part; the gap before the year may hold spaces.
          if (phase_q == PH_SKIP1 && !eof && sp) begin
            phase_d = PH_SKIP1;
          end else if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_UNEXP_END,
                                      (phase_q == PH_SKIP1) ? ert_pkg::SUBJ_YEAR :
                                      (phase_q == PH_MONTH_START) ? ert_pkg::SUBJ_MONTH :
                                      ert_pkg::SUBJ_DAY, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (dg) begin
            tok_start = 1'b1;
            dcnt_d    = 3'd1;
            phase_d   = (phase_q == PH_SKIP1) ? PH_YEAR :
                        (phase_q == PH_MONTH_START) ? PH_MONTH : PH_DAY;
          end else begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR,
                                      (phase_q == PH_SKIP1) ? ert_pkg::SUBJ_YEAR :
                                      (phase_q == PH_MONTH_START) ? ert_pkg::SUBJ_MONTH :
                                      ert_pkg::SUBJ_DAY, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end
        end
        PH_YEAR, PH_MONTH, PH_DAY: begin
          // Further digits of a date part until the part is complete.
          if (eof || !dg) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR,
                                      (phase_q == PH_YEAR) ? ert_pkg::SUBJ_YEAR :
                                      (phase_q == PH_MONTH) ? ert_pkg::SUBJ_MONTH :
                                      ert_pkg::SUBJ_DAY, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else begin
            tok_grow = 1'b1;
            dcnt_d   = dcnt_inc;
            if (dcnt_inc >= ((phase_q == PH_YEAR) ? YearDigits : PairDigits)) begin
              bd.slot[bd.cnt] = tok_res((phase_q == PH_YEAR) ? ert_pkg::SUBJ_YEAR :
                                        (phase_q == PH_MONTH) ? ert_pkg::SUBJ_MONTH :
                                        ert_pkg::SUBJ_DAY, 1'b0);
              bd.cnt = bd.cnt + 2'd1;
              phase_d = (phase_q == PH_YEAR) ? PH_DASH1 :
                        (phase_q == PH_MONTH) ? PH_DASH2 : PH_AFTER_DAY;
            end
          end
        end
        PH_DASH1, PH_DASH2: begin
          if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_UNEXP_END,
                                      (phase_q == PH_DASH1) ? ert_pkg::SUBJ_DASH1 :
                                      ert_pkg::SUBJ_DASH2, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (is_dash) begin
            phase_d = (phase_q == PH_DASH1) ? PH_MONTH_START : PH_DAY_START;
          end else begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR,
                                      (phase_q == PH_DASH1) ? ert_pkg::SUBJ_DASH1 :
                                      ert_pkg::SUBJ_DASH2, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end
        end
        PH_AFTER_DAY, PH_SKIP_PERSON: begin
          if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_UNEXP_END,
                                      (phase_q == PH_AFTER_DAY) ? ert_pkg::SUBJ_SPACES :
                                      ert_pkg::SUBJ_PERSON, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (sp) begin
            phase_d = PH_SKIP_PERSON;
          end else begin
            tok_start = 1'b1;
            phase_d   = PH_PERSON;
          end
        end
        PH_PERSON, PH_SHOP: begin
          // Free-form word ended by whitespace; end of data cuts it short.
          if (eof) begin
            bd.slot[bd.cnt] = tok_res((phase_q == PH_PERSON) ? ert_pkg::SUBJ_PERSON :
                                      ert_pkg::SUBJ_SHOP, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_SPACES, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (sp) begin
            bd.slot[bd.cnt] = tok_res((phase_q == PH_PERSON) ? ert_pkg::SUBJ_PERSON :
                                      ert_pkg::SUBJ_SHOP, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            if (phase_q == PH_PERSON) begin
              phase_d = PH_SKIP_SHOP;
            end else begin
              tag_seen_d = 1'b0;
              phase_d    = PH_TAG_START;
            end
          end else begin
            tok_grow = 1'b1;
          end
        end
        PH_SKIP_SHOP: begin
          if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_SHOP, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (!sp) begin
            tok_start = 1'b1;
            phase_d   = PH_SHOP;
          end
        end
        PH_TAG_START: begin
          if (eof) begin
            if (tag_seen_q) begin
              bd.slot[bd.cnt] = cur_res(ert_pkg::EV_TOKEN, ert_pkg::SUBJ_NOTE, 1'b1);
              bd.cnt = bd.cnt + 2'd1;
              bd.slot[bd.cnt] = cur_res(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT, 1'b0);
              bd.cnt = bd.cnt + 2'd1;
            end else begin
              bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_TAGS, 1'b0);
              bd.cnt = bd.cnt + 2'd1;
            end
            halt_now = 1'b1;
          end else if (sp) begin
            if (tag_seen_q) begin
              if (is_nl) begin
                bd.slot[bd.cnt] = cur_res(ert_pkg::EV_TOKEN, ert_pkg::SUBJ_NOTE, 1'b1);
                bd.cnt = bd.cnt + 2'd1;
                phase_d = PH_SKIP0;
              end else begin
                phase_d = PH_NOTE_SKIP;
              end
            end
          end else if (is_comma) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_TAG, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else begin
            tok_start = 1'b1;
            phase_d   = PH_TAG;
          end
        end
        PH_TAG: begin
          if (eof) begin
            bd.slot[bd.cnt] = tok_res(ert_pkg::SUBJ_TAG, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_TOKEN, ert_pkg::SUBJ_NOTE, 1'b1);
            bd.cnt = bd.cnt + 2'd1;
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (is_comma) begin
            bd.slot[bd.cnt] = tok_res(ert_pkg::SUBJ_TAG, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            tag_seen_d = 1'b1;
            phase_d    = PH_TAG_START;
          end else if (sp) begin
            bd.slot[bd.cnt] = tok_res(ert_pkg::SUBJ_TAG, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            tag_seen_d = 1'b1;
            if (is_nl) begin
              bd.slot[bd.cnt] = cur_res(ert_pkg::EV_TOKEN, ert_pkg::SUBJ_NOTE, 1'b1);
              bd.cnt = bd.cnt + 2'd1;
              phase_d = PH_SKIP0;
            end else begin
              phase_d = PH_NOTE_SKIP;
            end
          end else begin
            tok_grow = 1'b1;
          end
        end
        PH_NOTE_SKIP: begin
          if (eof) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_TOKEN, ert_pkg::SUBJ_NOTE, 1'b1);
            bd.cnt = bd.cnt + 2'd1;
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (is_nl) begin
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_TOKEN, ert_pkg::SUBJ_NOTE, 1'b1);
            bd.cnt = bd.cnt + 2'd1;
            phase_d = PH_SKIP0;
          end else if (!sp) begin
            tok_start = 1'b1;
            phase_d   = PH_NOTE;
          end
        end
        PH_NOTE: begin
          if (eof) begin
            bd.slot[bd.cnt] = tok_res(ert_pkg::SUBJ_NOTE, 1'b1);
            bd.cnt = bd.cnt + 2'd1;
            bd.slot[bd.cnt] = cur_res(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT, 1'b0);
            bd.cnt = bd.cnt + 2'd1;
            halt_now = 1'b1;
          end else if (is_nl) begin
            bd.slot[bd.cnt] = tok_res(ert_pkg::SUBJ_NOTE, 1'b1);
            bd.cnt = bd.cnt + 2'd1;
            phase_d = PH_SKIP0;
          end else begin
            tok_grow = 1'b1;
          end
        end
        default: begin
          phase_d = PH_SKIP0;
        end
      endcase
    end
  end

  // Token snapshot: start latches the cursor, grow counts one more byte.
  always_comb begin
    tofs_d  = tofs_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    tcnt_d  = tcnt_q;
    if (tok_start) begin
      tofs_d  = ofs_q;
      tline_d = line_q;
      tcol_d  = col_q;
      tcnt_d  = {{(ert_pkg::LenWidth-1){1'b0}}, 1'b1};
    end else if (tok_grow && !(&tcnt_q)) begin
      tcnt_d = tcnt_q + {{(ert_pkg::LenWidth-1){1'b0}}, 1'b1};
    end
  end

  // Cursor advance on every data byte that does not halt the parser.
  always_comb begin
    halted_d = halted_q | halt_now;
    ofs_d    = ofs_q;
    line_d   = line_q;
    col_d    = col_q;
    if (!halted_d && !eof) begin
      if (!(&ofs_q)) begin
        ofs_d = ofs_q + {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};
      end
      if (is_nl) begin
        col_d = {{(COL_WIDTH-1){1'b0}}, 1'b1};
        if (!(&line_q)) begin
          line_d = line_q + {{(LINE_WIDTH-1){1'b0}}, 1'b1};
        end
      end else if (!(&col_q)) begin
        col_d = col_q + {{(COL_WIDTH-1){1'b0}}, 1'b1};
      end
    end
  end

  // State registers, updated once per accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SKIP0;
      dcnt_q     <= 3'd0;
      tag_seen_q <= 1'b0;
      halted_q   <= 1'b0;
      ofs_q      <= '0;
      line_q     <= {{(LINE_WIDTH-1){1'b0}}, 1'b1};
      col_q      <= {{(COL_WIDTH-1){1'b0}}, 1'b1};
      tofs_q     <= '0;
      tline_q    <= {{(LINE_WIDTH-1){1'b0}}, 1'b1};
      tcol_q     <= {{(COL_WIDTH-1){1'b0}}, 1'b1};
      tcnt_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      dcnt_q     <= dcnt_d;
      tag_seen_q <= tag_seen_d;
      halted_q   <= halted_d;
      ofs_q      <= ofs_d;
      line_q     <= line_d;
      col_q      <= col_d;
      tofs_q     <= tofs_d;
      tline_q    <= tline_d;
      tcol_q     <= tcol_d;
      tcnt_q     <= tcnt_d;
    end
  end

  assign bundle_o   = bd;
  assign tok_off_o  = tofs_d;
  assign tok_len_o  = tcnt_d;
  assign tok_line_o = tline_d;
  assign tok_col_o  = tcol_d;
  assign cur_off_o  = ofs_q;
  assign cur_line_o = line_q;
  assign cur_col_o  = col_q;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for expense_record_tokenizer: a byte-level record parser
// predictor, a directed stimulus table, random record streams and a result scoreboard.
// Depends on ert_pkg and the expense_record_tokenizer RTL.
`timescale 1ns / 1ps

module tb;

  // Characters and digit counts of the record grammar.
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam int YEAR_DIGITS = 4;
  localparam int PAIR_DIGITS = 2;
  localparam int RANDOM_BEATS = 90;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 45;
  localparam int DRAIN_CYCLES = 8;

  // Parser position within one record.
  typedef enum logic [4:0] {
    P_LEAD, P_AMOUNT, P_DOT, P_FRAC1, P_FRAC2, P_GAP_DATE, P_YEAR, P_DASH1,
    P_MON0, P_MON, P_DASH2, P_DAY0, P_DAY, P_POST_DAY, P_GAP_PERSON, P_PERSON,
    P_GAP_SHOP, P_SHOP, P_TAG0, P_TAG, P_GAP_NOTE, P_NOTE
  } phase_e;

  // How a generated record ends after its tag list.
  typedef enum int {
    END_NL, END_COMMA_NL, END_WS_NL, END_NOTE, END_NOTE_EOF, END_TAG_EOF
  } ending_e;

  typedef struct {
    ert_pkg::event_e   ev;
    ert_pkg::subject_e subj;
    logic [31:0]       offs;
    logic [31:0]       len;
    logic [19:0]       line;
    logic [15:0]       col;
    logic              rend;
    logic              tail;
  } token_rec_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    bit         typed;
    token_rec_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  event_res_o;
  logic [3:0]  subject_o;
  logic [31:0] start_offset_o;
  logic [31:0] token_length_o;
  logic [19:0] start_line_o;
  logic [15:0] start_col_o;
  logic        record_end_o;
  logic        last_o;

  expense_record_tokenizer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .subject_o      (subject_o),
    .start_offset_o (start_offset_o),
    .token_length_o (token_length_o),
    .start_line_o   (start_line_o),
    .start_col_o    (start_col_o),
    .record_end_o   (record_end_o),
    .last_o         (last_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predictor state, a private copy of the parser's registers.
  phase_e      ph;
  logic [2:0]  ndig;
  bit          tags_done;
  bit          stopped;
  logic [31:0] cur_off;
  logic [19:0] cur_line;
  logic [15:0] cur_col;
  logic [31:0] t_off;
  logic [19:0] t_line;
  logic [15:0] t_col;
  logic [31:0] t_len;

  token_rec_t beat_res[$];
  token_rec_t pending_tokens[$];
  stim_row_t  stim_q[$];
  logic [7:0] rec_bytes[$];
  token_rec_t no_tok;

  int  fail_count = 0;
  int  beats_in = 0;
  int  results_seen = 0;
  int  records_seen = 0;
  int  rx_left = 0;
  int  rx_cyc = 0;
  logic press_hold = 1'b0;

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= 8'h39;
  endfunction

  // At most three results per beat; further ones are dropped as in the block.
  function automatic void put_res(ert_pkg::event_e ev, ert_pkg::subject_e sj,
                                  logic [31:0] offs, logic [31:0] len, logic [19:0] ln,
                                  logic [15:0] col, logic rend);
    token_rec_t r;
    if (beat_res.size() >= ert_pkg::MaxResults) return;
    r.ev = ev;
    r.subj = sj;
    r.offs = offs;
    r.len = len;
    r.line = ln;
    r.col = col;
    r.rend = rend;
    r.tail = 1'b0;
    beat_res.push_back(r);
  endfunction

  function automatic void tok_begin();
    t_off = cur_off;
    t_line = cur_line;
    t_col = cur_col;
    t_len = 32'd1;
  endfunction

  function automatic void tok_more();
    if (t_len != '1) t_len = t_len + 32'd1;
  endfunction

  function automatic void tok_out(ert_pkg::subject_e sj, logic rend);
    put_res(ert_pkg::EV_TOKEN, sj, t_off, t_len, t_line, t_col, rend);
  endfunction

  function automatic void note_empty();
    put_res(ert_pkg::EV_TOKEN, ert_pkg::SUBJ_NOTE, cur_off, 32'd0, cur_line, cur_col, 1'b1);
  endfunction

  function automatic void halt_with(ert_pkg::event_e ev, ert_pkg::subject_e sj);
    put_res(ev, sj, cur_off, 32'd0, cur_line, cur_col, 1'b0);
    stopped = 1'b1;
  endfunction

  // First digit of a date field.
  function automatic void date_lead(logic eof, logic [7:0] c, ert_pkg::subject_e sj,
                                    phase_e nxt);
    if (eof) halt_with(ert_pkg::EV_UNEXP_END, sj);
    else if (is_digit(c)) begin
      tok_begin();
      ndig = 3'd1;
      ph = nxt;
    end else halt_with(ert_pkg::EV_PARSE_ERR, sj);
  endfunction

  // Further digits of a date field; the token goes out on the last one.
  function automatic void date_digit(logic eof, logic [7:0] c, ert_pkg::subject_e sj,
                                     int need, phase_e nxt);
    if (eof || !is_digit(c)) begin
      halt_with(ert_pkg::EV_PARSE_ERR, sj);
      return;
    end
    tok_more();
    ndig = ndig + 3'd1;
    if (ndig >= need) begin
      tok_out(sj, 1'b0);
      ph = nxt;
    end
  endfunction

  function automatic void date_dash(logic eof, logic [7:0] c, ert_pkg::subject_e sj,
                                    phase_e nxt);
    if (eof) halt_with(ert_pkg::EV_UNEXP_END, sj);
    else if (c == CH_DASH) ph = nxt;
    else halt_with(ert_pkg::EV_PARSE_ERR, sj);
  endfunction

  // Work out the results of one input beat into beat_res and advance the state.
  function automatic void tokenize_byte(logic eof, logic [7:0] c);
    bit sp;
    bit dg;
    sp = is_space(c);
    dg = is_digit(c);
    beat_res.delete();
    if (stopped) return;
    case (ph)
      P_LEAD: begin
        if (eof) halt_with(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT);
        else if (!sp) begin
          tok_begin();
          if (dg) ph = P_AMOUNT;
          else halt_with(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_AMOUNT);
        end
      end
      P_AMOUNT: begin
        if (eof) halt_with(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_AMOUNT);
        else if (dg) tok_more();
        else if (c == CH_DOT) begin
          tok_more();
          ph = P_DOT;
        end else if (sp) begin
          tok_out(ert_pkg::SUBJ_AMOUNT, 1'b0);
          ph = P_GAP_DATE;
        end else halt_with(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_SPACES);
      end
      P_DOT: begin
        if (eof) halt_with(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_AMOUNT);
        else if (dg) begin
          tok_more();
          ph = P_FRAC1;
        end else halt_with(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_AMOUNT);
      end
      P_FRAC1: begin
        if (eof) halt_with(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_AMOUNT);
        else if (dg) begin
          tok_more();
          ph = P_FRAC2;
        end else if (sp) begin
          tok_out(ert_pkg::SUBJ_AMOUNT, 1'b0);
          ph = P_GAP_DATE;
        end else halt_with(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_SPACES);
      end
      P_FRAC2: begin
        if (eof) halt_with(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_SPACES);
        else if (sp) begin
          tok_out(ert_pkg::SUBJ_AMOUNT, 1'b0);
          ph = P_GAP_DATE;
        end else halt_with(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_SPACES);
      end
      P_GAP_DATE: begin
        if (eof || !sp) date_lead(eof, c, ert_pkg::SUBJ_YEAR, P_YEAR);
      end
      P_YEAR:  date_digit(eof, c, ert_pkg::SUBJ_YEAR, YEAR_DIGITS, P_DASH1);
      P_DASH1: date_dash(eof, c, ert_pkg::SUBJ_DASH1, P_MON0);
      P_MON0:  date_lead(eof, c, ert_pkg::SUBJ_MONTH, P_MON);
      P_MON:   date_digit(eof, c, ert_pkg::SUBJ_MONTH, PAIR_DIGITS, P_DASH2);
      P_DASH2: date_dash(eof, c, ert_pkg::SUBJ_DASH2, P_DAY0);
      P_DAY0:  date_lead(eof, c, ert_pkg::SUBJ_DAY, P_DAY);
      P_DAY:   date_digit(eof, c, ert_pkg::SUBJ_DAY, PAIR_DIGITS, P_POST_DAY);
      P_POST_DAY, P_GAP_PERSON: begin
        if (eof) begin
          if (ph == P_POST_DAY) halt_with(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_SPACES);
          else halt_with(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_PERSON);
        end else if (sp) ph = P_GAP_PERSON;
        else begin
          tok_begin();
          ph = P_PERSON;
        end
      end
      P_PERSON: begin
        if (eof) begin
          tok_out(ert_pkg::SUBJ_PERSON, 1'b0);
          halt_with(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_SPACES);
        end else if (sp) begin
          tok_out(ert_pkg::SUBJ_PERSON, 1'b0);
          ph = P_GAP_SHOP;
        end else tok_more();
      end
      P_GAP_SHOP: begin
        if (eof) halt_with(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_SHOP);
        else if (!sp) begin
          tok_begin();
          ph = P_SHOP;
        end
      end
      P_SHOP: begin
        if (eof) begin
          tok_out(ert_pkg::SUBJ_SHOP, 1'b0);
          halt_with(ert_pkg::EV_UNEXP_END, ert_pkg::SUBJ_SPACES);
        end else if (sp) begin
          tok_out(ert_pkg::SUBJ_SHOP, 1'b0);
          tags_done = 1'b0;
          ph = P_TAG0;
        end else tok_more();
      end
      P_TAG0: begin
        if (eof) begin
          if (tags_done) begin
            note_empty();
            halt_with(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT);
          end else halt_with(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_TAGS);
        end else if (sp) begin
          if (tags_done) begin
            if (c == CH_NL) begin
              note_empty();
              ph = P_LEAD;
            end else ph = P_GAP_NOTE;
          end
        end else if (c == CH_COMMA) halt_with(ert_pkg::EV_PARSE_ERR, ert_pkg::SUBJ_TAG);
        else begin
          tok_begin();
          ph = P_TAG;
        end
      end
      P_TAG: begin
        if (eof) begin
          tok_out(ert_pkg::SUBJ_TAG, 1'b0);
          note_empty();
          halt_with(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT);
        end else if (c == CH_COMMA) begin
          tok_out(ert_pkg::SUBJ_TAG, 1'b0);
          tags_done = 1'b1;
          ph = P_TAG0;
        end else if (sp) begin
          tok_out(ert_pkg::SUBJ_TAG, 1'b0);
          tags_done = 1'b1;
          if (c == CH_NL) begin
            note_empty();
            ph = P_LEAD;
          end else ph = P_GAP_NOTE;
        end else tok_more();
      end
      P_GAP_NOTE: begin
        if (eof) begin
          note_empty();
          halt_with(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT);
        end else if (c == CH_NL) begin
          note_empty();
          ph = P_LEAD;
        end else if (!sp) begin
          tok_begin();
          ph = P_NOTE;
        end
      end
      default: begin
        if (eof) begin
          tok_out(ert_pkg::SUBJ_NOTE, 1'b1);
          halt_with(ert_pkg::EV_FINISHED, ert_pkg::SUBJ_AMOUNT);
        end else if (c == CH_NL) begin
          tok_out(ert_pkg::SUBJ_NOTE, 1'b1);
          ph = P_LEAD;
        end else tok_more();
      end
    endcase

    // Every byte that does not halt the parser moves the cursor.
    if (!stopped && !eof) begin
      if (cur_off != '1) cur_off = cur_off + 32'd1;
      if (c == CH_NL) begin
        cur_col = 16'd1;
        if (cur_line != '1) cur_line = cur_line + 20'd1;
      end else if (cur_col != '1) cur_col = cur_col + 16'd1;
    end
    if (beat_res.size() > 0) beat_res[beat_res.size()-1].tail = 1'b1;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic token_rec_t want_tok(ert_pkg::subject_e sj, int offs, int len, int ln,
                                          int col);
    token_rec_t w;
    w.ev = ert_pkg::EV_TOKEN;
    w.subj = sj;
    w.offs = 32'(offs);
    w.len = 32'(len);
    w.line = 20'(ln);
    w.col = 16'(col);
    w.rend = 1'b0;
    w.tail = 1'b1;
    return w;
  endfunction

  function automatic void add_row(logic kind, logic [7:0] data, bit typed, token_rec_t want);
    stim_row_t r;
    r.kind = kind;
    r.data = data;
    r.typed = typed;
    r.want = want;
    stim_q.push_back(r);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    add_row(1'b0, b, 1'b0, no_tok);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_typed(logic [7:0] b, token_rec_t want);
    add_row(1'b0, b, 1'b1, want);
  endfunction

  // End of data carries a random byte that the block must ignore.
  function automatic void add_eof();
    add_row(1'b1, 8'($urandom), 1'b0, no_tok);
  endfunction

  function automatic logic [7:0] pick_ws(bit allow_nl);
    logic [7:0] others[4];
    int r;
    others = '{8'h09, 8'h0B, 8'h0C, 8'h0D};
    r = $urandom_range(0, 9);
    if (allow_nl && r == 0) return CH_NL;
    if (r <= 5) return CH_SPACE;
    return others[$urandom_range(0, 3)];
  endfunction

  // Any non-blank byte, high bytes included.
  function automatic logic [7:0] pick_text(bit no_comma);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (is_space(b) || (no_comma && b == CH_COMMA));
    return b;
  endfunction

  function automatic void push_sep(bit allow_nl);
    int n;
    n = $urandom_range(1, 2);
    repeat (n) rec_bytes.push_back(pick_ws(allow_nl));
  endfunction

  function automatic void push_digits(int n);
    repeat (n) rec_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  function automatic void push_text(int n, bit no_comma);
    repeat (n) rec_bytes.push_back(pick_text(no_comma));
  endfunction

  // Build one well-formed record with random content into rec_bytes.
  function automatic void gen_record(ending_e ending, int note_len);
    int n;
    logic [7:0] b;
    rec_bytes.delete();
    n = $urandom_range(0, 2);
    repeat (n) rec_bytes.push_back(pick_ws(1'b1));
    push_digits($urandom_range(1, 6));
    n = $urandom_range(0, 2);
    if (n > 0) begin
      rec_bytes.push_back(CH_DOT);
      push_digits(n);
    end
    push_sep(1'b1);
    push_digits(YEAR_DIGITS);
    rec_bytes.push_back(CH_DASH);
    push_digits(PAIR_DIGITS);
    rec_bytes.push_back(CH_DASH);
    push_digits(PAIR_DIGITS);
    push_sep(1'b1);
    push_text($urandom_range(1, 6), 1'b0);
    push_sep(1'b1);
    push_text($urandom_range(1, 6), 1'b0);
    push_sep(1'b1);
    n = $urandom_range(1, 3);
    for (int t = 0; t < n; t++) begin
      if (t > 0) rec_bytes.push_back(CH_COMMA);
      push_text($urandom_range(1, 5), 1'b1);
    end
    case (ending)
      END_NL: rec_bytes.push_back(CH_NL);
      END_COMMA_NL: begin
        rec_bytes.push_back(CH_COMMA);
        rec_bytes.push_back(CH_NL);
      end
      END_WS_NL: begin
        push_sep(1'b0);
        rec_bytes.push_back(CH_NL);
      end
      END_NOTE, END_NOTE_EOF: begin
        push_sep(1'b0);
        repeat (note_len) begin
          do b = 8'($urandom_range(0, 255));
          while (b == CH_NL);
          rec_bytes.push_back(b);
        end
        if (ending == END_NOTE) rec_bytes.push_back(CH_NL);
      end
      default: ;
    endcase
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Receiver: checks each accepted result beat and drives random stalls.
  always @(posedge clk_i) begin : rx_side
    token_rec_t want;
    int n;
    bit stall_now;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_tokens.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, event %0d subject %0d",
                   $time, event_res_o, subject_o);
          fail_count++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("event", 32'(want.ev), 32'(event_res_o));
          check_field("subject", 32'(want.subj), 32'(subject_o));
          check_field("start offset", want.offs, start_offset_o);
          check_field("length", want.len, token_length_o);
          check_field("line", 32'(want.line), 32'(start_line_o));
          check_field("column", 32'(want.col), 32'(start_col_o));
          check_field("record end", 32'(want.rend), 32'(record_end_o));
          check_field("last", 32'(want.tail), 32'(last_o));
          if (want.rend) records_seen++;
        end
      end
      rx_cyc++;
      if (rx_left > 0) begin
        rx_left--;
        stall_now = 1'b1;
      end else begin
        n = ((rx_cyc / 256) % 4 == 1) ? 0 : idle_len();
        stall_now = n > 0;
        rx_left = (n > 0) ? n - 1 : 0;
      end
      out_stall_i <= press_hold | stall_now;
    end
  end

  // Long receiver hold-off so the result buffer fills and the input stalls.
  initial begin
    wait (beats_in >= HOLD_AFTER);
    @(posedge clk_i);
    press_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    press_hold <= 1'b0;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("Timeout with %0d results still expected", pending_tokens.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus build, reset and sender.
  initial begin
    stim_row_t row;
    int gap;
    int rand_items;
    int cut;
    int pick;

    ph = P_LEAD;
    ndig = 3'd0;
    tags_done = 1'b0;
    stopped = 1'b0;
    cur_off = 32'd0;
    cur_line = 20'd1;
    cur_col = 16'd1;
    t_off = 32'd0;
    t_line = 20'd1;
    t_col = 16'd1;
    t_len = 32'd0;
    no_tok = want_tok(ert_pkg::SUBJ_AMOUNT, 0, 0, 1, 1);

    // Directed record from reset: smallest amount, all-nines year, zero month,
    // high bytes as person and shop, one tag, no note, then blank lines.
    add_text("0");
    add_typed(" ", want_tok(ert_pkg::SUBJ_AMOUNT, 0, 1, 1, 1));
    add_text("999");
    add_typed("9", want_tok(ert_pkg::SUBJ_YEAR, 2, 4, 1, 3));
    add_text("-0");
    add_typed("0", want_tok(ert_pkg::SUBJ_MONTH, 7, 2, 1, 8));
    add_text("-9");
    add_typed("9", want_tok(ert_pkg::SUBJ_DAY, 10, 2, 1, 11));
    add_text(" ");
    add_byte(8'h80);
    add_typed(" ", want_tok(ert_pkg::SUBJ_PERSON, 13, 1, 1, 14));
    add_byte(8'hFF);
    add_typed(" ", want_tok(ert_pkg::SUBJ_SHOP, 15, 1, 1, 16));
    add_text("t\n\t\r\n");

    // Random well-formed records with every kind of line ending.
    rand_items = 0;
    while (rand_items < RANDOM_BEATS) begin
      gen_record(ending_e'($urandom_range(END_NL, END_NOTE)), $urandom_range(1, 10));
      rand_items += rec_bytes.size();
      foreach (rec_bytes[i]) add_byte(rec_bytes[i]);
    end

    // The stream ends once: cleanly, cut short, broken, or inside a field.
    pick = $urandom_range(0, 4);
    case (pick)
      0: ;
      1, 2: begin
        gen_record(END_NOTE, $urandom_range(1, 10));
        cut = $urandom_range(1, rec_bytes.size() - 1);
        for (int i = 0; i < cut; i++) add_byte(rec_bytes[i]);
        if (pick == 2) repeat ($urandom_range(1, 2)) add_byte(8'($urandom_range(0, 255)));
      end
      3: begin
        gen_record(END_NOTE_EOF, $urandom_range(1, 10));
        foreach (rec_bytes[i]) add_byte(rec_bytes[i]);
      end
      default: begin
        gen_record(END_TAG_EOF, 0);
        foreach (rec_bytes[i]) add_byte(rec_bytes[i]);
      end
    endcase
    add_eof();
    // A halted parser takes these beats without results.
    repeat (3) add_row(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, no_tok);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < stim_q.size(); i++) begin
      row = stim_q[i];
      gap = ((i / 32) % 3 == 1) ? 0 : idle_len();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      kind_i <= row.kind;
      data_byte_i <= row.data;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      // The beat was taken at this edge.
      beats_in++;
      tokenize_byte(row.kind, row.data);
      if (row.typed) pending_tokens.push_back(row.want);
      else foreach (beat_res[k]) pending_tokens.push_back(beat_res[k]);
    end
    in_valid_i <= 1'b0;

    wait (pending_tokens.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_tokens.size() != 0) begin
      $display("%0d expected results never arrived", pending_tokens.size());
      fail_count++;
    end

    $display("Run covered %0d input beats and %0d result beats over %0d complete records,",
             beats_in, results_seen, records_seen);
    $display("with a %0d-cycle receiver hold-off and stream end case %0d.",
             HOLD_CYCLES, pick);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
